/* rtl/page_table_mapper_defines.svh */
// assertion macros for the page table mapper files
`ifndef PAGE_TABLE_MAPPER_DEFINES_SVH
`define PAGE_TABLE_MAPPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table mapper assertion failed");

// next-cycle implication, disabled in reset
`define PTM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table mapper assertion failed");

`endif

/* rtl/ptm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

  // pool geometry
  localparam int POOL_PAGES = 16;
  localparam int IDX_W      = 9;
  localparam int ENTRIES    = 1 << IDX_W;
  localparam int PAGE_W     = $clog2(POOL_PAGES);
  localparam int CNT_W      = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W     = PAGE_W + IDX_W;
  localparam int MEM_DEPTH  = POOL_PAGES * ENTRIES;
  localparam int PG_CMP_W   = 9;

  // entry layout
  localparam int BASE_W     = 40;
  localparam int SHIFT_PT   = 12;
  localparam int SHIFT_PD   = 21;
  localparam int SHIFT_PDPT = 30;
  localparam int SHIFT_PML4 = 39;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 52;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_FLAGS = 1'd1;
  localparam logic [11:0] DEF_FLAGS_RST = 12'h003;

  // request codes
  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE   = 2'd2;

  localparam logic [1:0] LVL_LAST = 2'd2;

  typedef struct packed {
    logic        op;
    logic [47:0] virt;
    logic [63:0] phys;
    logic [63:0] flags;
    logic [3:0]  read_page;
    logic [8:0]  read_index;
  } ptm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [4:0]  pages_used;
  } ptm_out_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic issue;
    logic eval;
    logic leaf;
    logic push;
  } ptm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic op_read;
    logic err;
    logic last_lvl;
  } ptm_sts_t;

endpackage

`default_nettype wire

/* rtl/page_table_mapper.sv */
// channel   direction  handshake             beat
// in_       input      in_valid / in_stall   ptm_in_t: op, virt, phys, flags, read page/index
// out_      output     out_valid / out_stall ptm_out_t: status, read_data, pages_used
// cfg_      input      cfg_we                cfg_index, cfg_wdata (52 bits)
//
// a read request issues one pool read and evaluates it before its result; a map request
// reads and evaluates each table level on the pool's registered read port, then one leaf write
// a map that stops on an error finishes after its last evaluated level
// after reset a clearing pass writes all POOL_PAGES*512 entries with in_stall high
// one request is in flight at a time; the next beat is taken while a result waits in out_data
// a stalled result holds the controller before it delivers the next result
`timescale 1ns / 1ps
`default_nettype none
`include "page_table_mapper_defines.svh"

module page_table_mapper import ptm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ptm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ptm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BASE_W-1:0] base_r;
  logic [11:0]       dflt_r;
  logic              out_valid_r;
  ptm_out_t          out_data_r;
  logic              out_free;
  ptm_cmd_t          cmd;
  ptm_sts_t          sts;
  logic [1:0]        dp_status;
  logic [63:0]       dp_rdata;
  logic [CNT_W-1:0]  dp_pages;
  logic [31:0]       pages_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      dflt_r <= DEF_FLAGS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE: base_r <= cfg_wdata[51:12];
        CFG_DEF_FLAGS: dflt_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  ptm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ptm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_data),
    .base       (base_r),
    .dflt       (dflt_r),
    .status     (dp_status),
    .read_data  (dp_rdata),
    .pages_used (dp_pages)
  );

  // result register
  assign out_free  = !out_valid_r || !out_stall;
  assign pages_ext = 32'(dp_pages);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.status     <= dp_status;
      out_data_r.read_data  <= dp_rdata;
      out_data_r.pages_used <= pages_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PTM_ASSERT_IMP(a_no_accept_in_clear, cmd.clr, in_stall)
  `PTM_ASSERT_IMP(a_no_push_on_accept, in_valid && !in_stall, !cmd.push)
  `PTM_ASSERT_NXT(a_push_shows_result, cmd.push, out_valid)
  `PTM_ASSERT_IMP(a_status_code, out_valid, out_data.status != 2'd3)

endmodule

`default_nettype wire

/* rtl/ptm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptm_datapath import ptm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ptm_cmd_t          cmd,
  output ptm_sts_t          sts,
  input  ptm_in_t           in_data,
  input  logic [BASE_W-1:0] base,
  input  logic [11:0]       dflt,
  output logic [1:0]        status,
  output logic [63:0]       read_data,
  output logic [CNT_W-1:0]  pages_used
);

  // table pool: bit 64 is the page epoch the entry was written in
  logic [64:0] mem [MEM_DEPTH];
  logic [64:0] mem_rd_r;

  logic              op_r;
  logic [47:0]       virt_r;
  logic [63:0]       leaf_r;
  logic [3:0]        rpage_r;
  logic [IDX_W-1:0]  rindex_r;
  logic [PAGE_W-1:0] table_r;
  logic [1:0]        lvl_r;
  logic [CNT_W-1:0]  next_free_r;
  logic [POOL_PAGES-1:0] alloc_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [1:0]        status_r;
  logic [63:0]       rdata_r;

  logic [IDX_W-1:0]  walk_idx;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] leaf_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PAGE_W-1:0] rd_page;
  logic              rd_in_range;
  logic              rd_en;
  logic [63:0]       ent;
  logic              present;
  logic [BASE_W-1:0] off;
  logic              outside;
  logic              exhausted;
  logic              err;
  logic [PAGE_W-1:0] nf_page;
  logic [BASE_W-1:0] link_addr;
  logic [63:0]       link;
  logic              new_tag;
  logic              do_alloc;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [64:0]       wr_data;

  // entry index for the current level
  always_comb begin
    case (lvl_r)
      2'd0:    walk_idx = virt_r[SHIFT_PML4 +: IDX_W];
      2'd1:    walk_idx = virt_r[SHIFT_PDPT +: IDX_W];
      default: walk_idx = virt_r[SHIFT_PD +: IDX_W];
    endcase
  end

  assign walk_addr = {table_r, walk_idx};
  assign leaf_addr = {table_r, virt_r[SHIFT_PT +: IDX_W]};

  // read address, and the page it falls in for the epoch check
  assign rd_page     = (op_r == OP_READ) ? PAGE_W'(rpage_r) : table_r;
  assign rd_in_range = (op_r == OP_READ) ?
                       (PG_CMP_W'(rpage_r) < PG_CMP_W'(POOL_PAGES)) : 1'b1;
  assign rd_addr     = (op_r == OP_READ) ? {PAGE_W'(rpage_r), rindex_r} : walk_addr;
  assign rd_en       = cmd.issue && rd_in_range;

  // an entry from before its page was handed out reads as zero
  assign ent = (mem_rd_r[64] == alloc_r[rd_page]) ? mem_rd_r[63:0] : 64'd0;

  // walk decision
  assign present   = ent[0];
  assign off       = ent[51:12] - base;
  assign outside   = off >= BASE_W'(POOL_PAGES);
  assign exhausted = next_free_r >= CNT_W'(POOL_PAGES);
  assign err       = present ? outside : exhausted;
  assign nf_page   = next_free_r[PAGE_W-1:0];
  assign link_addr = base + BASE_W'(next_free_r);
  assign link      = {12'd0, link_addr, 12'd0} | {52'd0, dflt};
  assign do_alloc  = cmd.eval && (op_r == OP_MAP) && !present && !exhausted;
  // the linking entry may sit in the page being handed out
  assign new_tag   = alloc_r[table_r] | (nf_page == table_r);

  // single write port: clearing pass, new link, leaf entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_addr;
    wr_data = {new_tag, link};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = 65'd0;
    end else if (do_alloc) begin
      wr_en   = 1'b1;
    end else if (cmd.leaf) begin
      wr_en   = 1'b1;
      wr_addr = leaf_addr;
      wr_data = {alloc_r[table_r], leaf_r};
    end
  end

  // pool memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= CNT_W'(1);
      alloc_r     <= '0;
      clr_addr_r  <= '0;
      table_r     <= '0;
      lvl_r       <= 2'd0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.load) begin
        table_r <= '0;
        lvl_r   <= 2'd0;
      end else if (cmd.eval && (op_r == OP_MAP)) begin
        lvl_r <= lvl_r + 1'b1;
        if (present && !outside) begin
          table_r <= off[PAGE_W-1:0];
        end else if (do_alloc) begin
          table_r <= nf_page;
        end
      end
      if (do_alloc) begin
        alloc_r[nf_page] <= 1'b1;
        next_free_r      <= next_free_r + 1'b1;
      end
    end
  end

  // request capture and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_data.op;
      virt_r   <= in_data.virt;
      leaf_r   <= in_data.phys | in_data.flags;
      rpage_r  <= in_data.read_page;
      rindex_r <= in_data.read_index;
      status_r <= ST_OK;
      rdata_r  <= 64'd0;
    end else if (cmd.eval) begin
      if (op_r == OP_READ) begin
        rdata_r <= rd_in_range ? ent : 64'd0;
      end else if (err) begin
        status_r <= present ? ST_OUTSIDE : ST_EXHAUSTED;
      end
    end
  end

  assign sts.clr_done = clr_addr_r == ADDR_W'(MEM_DEPTH - 1);
  assign sts.op_read  = op_r == OP_READ;
  assign sts.err      = err;
  assign sts.last_lvl = lvl_r == LVL_LAST;

  assign status     = status_r;
  assign read_data  = rdata_r;
  assign pages_used = next_free_r;

endmodule

`default_nettype wire

/* rtl/ptm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptm_ctrl import ptm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  output logic     in_stall,
  output ptm_cmd_t cmd,
  input  ptm_sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.issue = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (sts.op_read || sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.last_lvl) begin
          state_nxt = S_LEAF;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_LEAF: begin
        cmd.leaf  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

`default_nettype wire
